[rtl/dts_pkg.sv]
package dts_pkg;

    localparam int TIME_W  = 48;
    localparam int ID_W    = 16;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int TCOUNT_W = 5;

    localparam logic [OP_W-1:0] OP_SCHED  = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

    localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REPEAT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_POINT  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_REJECT = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    localparam logic KIND_RESP = 1'b0;
    localparam logic KIND_FIRE = 1'b1;

    localparam logic [1:0] SCAN_NONE = 2'd0;
    localparam logic [1:0] SCAN_ID   = 2'd1;
    localparam logic [1:0] SCAN_MIN  = 2'd2;
    localparam logic [1:0] SCAN_FIRE = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] deadline;
    } slot_t;

    typedef struct packed {
        logic       capture;
        logic       scan_clear;
        logic       rd_en;
        logic [1:0] scan_kind;
        logic       commit;
    } cmd_t;

    typedef struct packed {
        logic due;
    } stat_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

[rtl/dts_ctrl.sv]
module dts_ctrl #(
    parameter int NUM_SLOTS = 16,
    localparam int IDXW = $clog2(NUM_SLOTS)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [dts_pkg::OP_W-1:0]      opcode,
    input  dts_pkg::stat_t                stat,
    output logic                          busy,
    output dts_pkg::cmd_t                 cmd,
    output logic [IDXW-1:0]               rd_addr
);
    import dts_pkg::*;

    localparam int CNTW = $clog2(NUM_SLOTS + 1);
    localparam logic [CNTW-1:0] CNT_END = CNTW'(NUM_SLOTS);

    localparam logic [2:0] S_IDLE      = 3'd0;
    localparam logic [2:0] S_SCAN_ID   = 3'd1;
    localparam logic [2:0] S_COMMIT    = 3'd2;
    localparam logic [2:0] S_SCAN_MIN  = 3'd3;
    localparam logic [2:0] S_DECIDE    = 3'd4;
    localparam logic [2:0] S_SCAN_FIRE = 3'd5;

    logic [2:0]      state_reg, state_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        cmd           = '0;
        cmd.scan_kind = SCAN_NONE;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    case (opcode)
                        OP_SCHED, OP_REMOVE:
                        begin
                            state_next     = S_SCAN_ID;
                            cnt_next       = '0;
                            cmd.scan_clear = 1'b1;
                        end
                        OP_TICK:
                        begin
                            state_next     = S_SCAN_MIN;
                            cnt_next       = '0;
                            cmd.scan_clear = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN_ID:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg != CNT_END)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.scan_kind = SCAN_ID;
                end
                else
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                state_next = S_IDLE;
            end
            S_SCAN_MIN:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg != CNT_END)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.scan_kind = SCAN_MIN;
                end
                else
                begin
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                cnt_next   = '0;
                state_next = stat.due ? S_SCAN_FIRE : S_IDLE;
            end
            S_SCAN_FIRE:
            begin
                cnt_next = cnt_reg + CNTW'(1);
                if (cnt_reg != CNT_END)
                begin
                    cmd.rd_en     = 1'b1;
                    cmd.scan_kind = SCAN_FIRE;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy    = (state_reg != S_IDLE);
    assign rd_addr = cnt_reg[IDXW-1:0];

endmodule

[rtl/dts_dp.sv]
module dts_dp #(
    parameter int NUM_SLOTS = 16,
    localparam int IDXW = $clog2(NUM_SLOTS)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dts_pkg::cmd_t                   cmd,
    input  logic [IDXW-1:0]                 rd_addr,
    input  logic [dts_pkg::OP_W-1:0]        opcode,
    input  logic [dts_pkg::ID_W-1:0]        task_id,
    input  logic [dts_pkg::MODE_W-1:0]      sched_mode,
    input  logic [dts_pkg::TIME_W-1:0]      time_value,
    input  logic                            task_ok,
    output dts_pkg::stat_t                  stat,
    output logic                            done,
    output logic                            result_kind,
    output logic [dts_pkg::STAT_W-1:0]      status,
    output logic [dts_pkg::ID_W-1:0]        fired_id,
    output logic [dts_pkg::TCOUNT_W-1:0]    task_count,
    output logic                            last
);
    import dts_pkg::*;

    localparam int CW = $clog2(NUM_SLOTS + 1);

    // slot table
    slot_t mem [NUM_SLOTS];
    slot_t rd_data_reg;
    logic [IDXW-1:0] rd_idx_reg;
    logic [1:0] rd_kind_reg;
    logic wr_en;
    logic [IDXW-1:0] wr_addr;
    slot_t wr_data;

    logic [NUM_SLOTS-1:0] valid_reg, valid_next;
    logic [CW-1:0] count_reg, count_next;
    logic [TIME_W-1:0] now_reg, now_next;

    logic [OP_W-1:0] op_reg;
    logic [ID_W-1:0] id_reg;
    logic [MODE_W-1:0] mode_reg;
    logic [TIME_W-1:0] tv_reg;
    logic ok_reg;

    logic match_reg, match_next, free_reg, free_next, any_reg, any_next;
    logic [IDXW-1:0] midx_reg, midx_next, fidx_reg, fidx_next, lidx_reg, lidx_next;
    logic [TIME_W-1:0] top_reg, top_next;

    logic done_reg, done_next;
    logic kind_reg, kind_next;
    logic [STAT_W-1:0] st_reg, st_next;
    logic [ID_W-1:0] oid_reg, oid_next;
    logic [TCOUNT_W-1:0] tc_reg, tc_next;
    logic last_reg, last_next;

    logic rd_valid;
    logic reject;
    logic [IDXW-1:0] sel_idx;
    logic [TIME_W-1:0] new_dl;
    logic [CW+TCOUNT_W-1:0] count_ext;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_kind_reg <= SCAN_NONE;
            valid_reg   <= '0;
            count_reg   <= '0;
            now_reg     <= '0;
            match_reg   <= 1'b0;
            free_reg    <= 1'b0;
            any_reg     <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            rd_kind_reg <= cmd.rd_en ? cmd.scan_kind : SCAN_NONE;
            valid_reg   <= valid_next;
            count_reg   <= count_next;
            now_reg     <= now_next;
            match_reg   <= match_next;
            free_reg    <= free_next;
            any_reg     <= any_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg <= rd_addr;
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            id_reg   <= task_id;
            mode_reg <= sched_mode;
            tv_reg   <= time_value;
            ok_reg   <= task_ok;
        end
        midx_reg <= midx_next;
        fidx_reg <= fidx_next;
        lidx_reg <= lidx_next;
        top_reg  <= top_next;
        kind_reg <= kind_next;
        st_reg   <= st_next;
        oid_reg  <= oid_next;
        tc_reg   <= tc_next;
        last_reg <= last_next;
    end

    assign rd_valid = valid_reg[rd_idx_reg];
    assign reject   = !ok_reg || (mode_reg == MODE_UNDEF)
                      || ((mode_reg == MODE_POINT) && (tv_reg < now_reg));
    assign sel_idx  = match_reg ? midx_reg : fidx_reg;
    assign new_dl   = sat_add(now_reg, rd_data_reg.period);

    always_comb
    begin
        valid_next = valid_reg;
        count_next = count_reg;
        now_next   = now_reg;
        match_next = match_reg;
        free_next  = free_reg;
        any_next   = any_reg;
        midx_next  = midx_reg;
        fidx_next  = fidx_reg;
        lidx_next  = lidx_reg;
        top_next   = top_reg;
        wr_en      = 1'b0;
        wr_addr    = rd_idx_reg;
        wr_data    = rd_data_reg;
        done_next  = 1'b0;
        kind_next  = kind_reg;
        st_next    = st_reg;
        oid_next   = oid_reg;
        last_next  = last_reg;

        if (cmd.capture && (opcode == OP_TICK))
        begin
            now_next = sat_add(now_reg, TIME_W'(1));
        end
        if (cmd.scan_clear)
        begin
            match_next = 1'b0;
            free_next  = 1'b0;
            any_next   = 1'b0;
        end

        case (rd_kind_reg)
            SCAN_ID:
            begin
                if (rd_valid && (rd_data_reg.id == id_reg) && !match_reg)
                begin
                    match_next = 1'b1;
                    midx_next  = rd_idx_reg;
                end
                if (!rd_valid && !free_reg)
                begin
                    free_next = 1'b1;
                    fidx_next = rd_idx_reg;
                end
            end
            SCAN_MIN:
            begin
                if (rd_valid)
                begin
                    if (!any_reg || (rd_data_reg.deadline < top_reg))
                    begin
                        any_next  = 1'b1;
                        top_next  = rd_data_reg.deadline;
                        lidx_next = rd_idx_reg;
                    end
                    else if (rd_data_reg.deadline == top_reg)
                    begin
                        lidx_next = rd_idx_reg;
                    end
                end
            end
            SCAN_FIRE:
            begin
                if (rd_valid && (rd_data_reg.deadline == top_reg))
                begin
                    if (rd_data_reg.mode == MODE_REPEAT)
                    begin
                        wr_en            = 1'b1;
                        wr_data.deadline = new_dl;
                    end
                    else
                    begin
                        valid_next[rd_idx_reg] = 1'b0;
                        count_next             = count_reg - CW'(1);
                    end
                    done_next = 1'b1;
                    kind_next = KIND_FIRE;
                    st_next   = ST_OK;
                    oid_next  = rd_data_reg.id;
                    last_next = (rd_idx_reg == lidx_reg);
                end
            end
            default:
            begin
            end
        endcase

        if (cmd.commit)
        begin
            done_next = 1'b1;
            kind_next = KIND_RESP;
            oid_next  = id_reg;
            last_next = 1'b1;
            st_next   = ST_OK;
            if (op_reg == OP_SCHED)
            begin
                if (reject)
                begin
                    st_next = ST_REJECT;
                end
                else if (match_reg || free_reg)
                begin
                    wr_en            = 1'b1;
                    wr_addr          = sel_idx;
                    wr_data.id       = id_reg;
                    wr_data.mode     = mode_reg;
                    wr_data.period   = tv_reg;
                    wr_data.deadline = (mode_reg == MODE_POINT) ? tv_reg
                                       : sat_add(now_reg, tv_reg);
                    valid_next[sel_idx] = 1'b1;
                    if (!match_reg)
                    begin
                        count_next = count_reg + CW'(1);
                    end
                end
                else
                begin
                    st_next = ST_FULL;
                end
            end
            else if (match_reg)
            begin
                valid_next[midx_reg] = 1'b0;
                count_next           = count_reg - CW'(1);
            end
        end
    end

    assign count_ext = {{TCOUNT_W{1'b0}}, count_next};
    assign tc_next   = count_ext[TCOUNT_W-1:0];

    assign stat.due    = any_reg && (top_reg <= now_reg);
    assign done        = done_reg;
    assign result_kind = kind_reg;
    assign status      = st_reg;
    assign fired_id    = oid_reg;
    assign task_count  = tc_reg;
    assign last        = last_reg;

endmodule

[rtl/deadline_task_scheduler.sv]
// Schedule and remove: an ID scan of the slot table, then a commit state; one result word strobed on done after that.
// Tick: a scan for the earliest deadline, a decide state, and if due a second scan that
// gives one fired word per due slot.
// One command in flight at a time; the slot table memory scan (one slot a cycle) sets how long busy stays high.
// Results cannot be stalled: each word is on the ports for one cycle only.
// Reset (rst_n low, asynchronous) clears the clock, all slot valid bits and the count.
module deadline_task_scheduler #(
    parameter int NUM_SLOTS = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dts_pkg::OP_W-1:0]        opcode,
    input  logic [dts_pkg::ID_W-1:0]        task_id,
    input  logic [dts_pkg::MODE_W-1:0]      sched_mode,
    input  logic [dts_pkg::TIME_W-1:0]      time_value,
    input  logic                            task_ok,
    output logic                            done,
    output logic                            result_kind,
    output logic [dts_pkg::STAT_W-1:0]      status,
    output logic [dts_pkg::ID_W-1:0]        fired_id,
    output logic [dts_pkg::TCOUNT_W-1:0]    task_count,
    output logic                            last
);
    import dts_pkg::*;

    localparam int IDXW = $clog2(NUM_SLOTS);

    cmd_t cmd;
    stat_t stat;
    logic [IDXW-1:0] rd_addr;

    dts_ctrl #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .opcode  (opcode),
        .stat    (stat),
        .busy    (busy),
        .cmd     (cmd),
        .rd_addr (rd_addr)
    );

    dts_dp #(
        .NUM_SLOTS(NUM_SLOTS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .opcode      (opcode),
        .task_id     (task_id),
        .sched_mode  (sched_mode),
        .time_value  (time_value),
        .task_ok     (task_ok),
        .stat        (stat),
        .done        (done),
        .result_kind (result_kind),
        .status      (status),
        .fired_id    (fired_id),
        .task_count  (task_count),
        .last        (last)
    );

endmodule

[tb/sv/deadline_task_scheduler_tb.sv]
module deadline_task_scheduler_tb;
    import dts_pkg::*;

    localparam int SLOTS = 16;
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_WORDS = 110;
    localparam logic [OP_W-1:0] OP_UNDEF = 2'd3;

    typedef struct packed {
        logic                kind;
        logic [STAT_W-1:0]   status;
        logic [ID_W-1:0]     id;
        logic [TCOUNT_W-1:0] count;
        logic                last;
    } timer_word_t;

    // mirror of the slot table; queues the words each accepted command should produce
    class timer_table_tracker;
        bit [TIME_W-1:0] clock_ms;
        bit              live[SLOTS];
        bit [ID_W-1:0]   ids[SLOTS];
        bit [MODE_W-1:0] modes[SLOTS];
        bit [TIME_W-1:0] periods[SLOTS];
        bit [TIME_W-1:0] deadlines[SLOTS];
        timer_word_t     awaited[$];
        int              errors;
        int              cmds;
        int              words;
        int              fires;
        int              widest_burst;

        function new();
            clock_ms = '0;
            foreach (live[i])
            begin
                live[i] = 1'b0;
            end
            errors = 0;
            cmds = 0;
            words = 0;
            fires = 0;
            widest_burst = 0;
        endfunction

        function bit [TIME_W-1:0] add_sat(input bit [TIME_W-1:0] a, input bit [TIME_W-1:0] b);
            bit [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            if (s[TIME_W])
            begin
                return {TIME_W{1'b1}};
            end
            return s[TIME_W-1:0];
        endfunction

        function int live_count();
            int n;
            n = 0;
            foreach (live[i])
            begin
                if (live[i])
                begin
                    n++;
                end
            end
            return n;
        endfunction

        function int slot_of(input bit [ID_W-1:0] id);
            foreach (live[i])
            begin
                if (live[i] && ids[i] == id)
                begin
                    return i;
                end
            end
            return -1;
        endfunction

        function void push_word(input logic kind, input logic [STAT_W-1:0] status,
                                input logic [ID_W-1:0] id, input logic last);
            timer_word_t w;
            int n;
            n = live_count();
            w.kind = kind;
            w.status = status;
            w.id = id;
            w.count = n[TCOUNT_W-1:0];
            w.last = last;
            awaited.push_back(w);
        endfunction

        function void accept_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                 input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] tv,
                                 input logic ok);
            int s;
            int end_slot;
            int burst;
            bit any;
            bit [TIME_W-1:0] dl;
            bit [TIME_W-1:0] top;
            bit due[SLOTS];
            cmds++;
            if (op == OP_SCHED)
            begin
                if (!ok || mode == MODE_UNDEF || (mode == MODE_POINT && tv < clock_ms))
                begin
                    push_word(KIND_RESP, ST_REJECT, id, 1'b1);
                    return;
                end
                dl = (mode == MODE_POINT) ? tv : add_sat(clock_ms, tv);
                s = slot_of(id);
                if (s < 0)
                begin
                    foreach (live[i])
                    begin
                        if (s < 0 && !live[i])
                        begin
                            s = i;
                        end
                    end
                end
                if (s < 0)
                begin
                    push_word(KIND_RESP, ST_FULL, id, 1'b1);
                    return;
                end
                live[s] = 1'b1;
                ids[s] = id;
                modes[s] = mode;
                periods[s] = tv;
                deadlines[s] = dl;
                push_word(KIND_RESP, ST_OK, id, 1'b1);
            end
            else if (op == OP_REMOVE)
            begin
                s = slot_of(id);
                if (s >= 0)
                begin
                    live[s] = 1'b0;
                end
                push_word(KIND_RESP, ST_OK, id, 1'b1);
            end
            else if (op == OP_TICK)
            begin
                clock_ms = add_sat(clock_ms, TIME_W'(1));
                any = 1'b0;
                top = '0;
                foreach (live[i])
                begin
                    if (live[i] && (!any || deadlines[i] < top))
                    begin
                        top = deadlines[i];
                        any = 1'b1;
                    end
                end
                if (!any || top > clock_ms)
                begin
                    return;
                end
                end_slot = -1;
                foreach (live[i])
                begin
                    due[i] = live[i] && deadlines[i] == top;
                    if (due[i])
                    begin
                        end_slot = i;
                    end
                end
                burst = 0;
                foreach (due[i])
                begin
                    if (due[i])
                    begin
                        if (modes[i] == MODE_REPEAT)
                        begin
                            deadlines[i] = add_sat(clock_ms, periods[i]);
                        end
                        else
                        begin
                            live[i] = 1'b0;
                        end
                        push_word(KIND_FIRE, ST_OK, ids[i], i == end_slot);
                        burst++;
                    end
                end
                if (burst > widest_burst)
                begin
                    widest_burst = burst;
                end
            end
        endfunction

        function void check_word(input logic kind, input logic [STAT_W-1:0] status,
                                 input logic [ID_W-1:0] id, input logic [TCOUNT_W-1:0] count,
                                 input logic last);
            timer_word_t want;
            words++;
            if (kind === KIND_FIRE)
            begin
                fires++;
            end
            if (awaited.size() == 0)
            begin
                $error("unexpected result word: result_kind %0d fired_id %h", kind, id);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (kind !== want.kind)
            begin
                $error("result_kind: expected %0d, got %0d", want.kind, kind);
                errors++;
            end
            if (status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, status);
                errors++;
            end
            if (id !== want.id)
            begin
                $error("fired_id: expected %h, got %h", want.id, id);
                errors++;
            end
            if (count !== want.count)
            begin
                $error("task_count: expected %0d, got %0d", want.count, count);
                errors++;
            end
            if (last !== want.last)
            begin
                $error("last: expected %0d, got %0d", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    logic [OP_W-1:0]     opcode;
    logic [ID_W-1:0]     task_id;
    logic [MODE_W-1:0]   sched_mode;
    logic [TIME_W-1:0]   time_value;
    logic                task_ok;
    logic                done;
    logic                result_kind;
    logic [STAT_W-1:0]   status;
    logic [ID_W-1:0]     fired_id;
    logic [TCOUNT_W-1:0] task_count;
    logic                last;

    timer_table_tracker tracker = new();
    int idle_cycles;
    bit steady_block;

    deadline_task_scheduler #(
        .NUM_SLOTS(SLOTS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .opcode(opcode),
        .task_id(task_id),
        .sched_mode(sched_mode),
        .time_value(time_value),
        .task_ok(task_ok),
        .done(done),
        .result_kind(result_kind),
        .status(status),
        .fired_id(fired_id),
        .task_count(task_count),
        .last(last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            tracker.check_word(result_kind, status, fired_id, task_count, last);
        end
    end

    // cycles with neither a command nor a result word
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_cycles <= 0;
        end
        else if ((start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic issue_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] tv,
                             input logic ok);
        opcode <= op;
        task_id <= id;
        sched_mode <= mode;
        time_value <= tv;
        task_ok <= ok;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
        begin
            @(posedge clk);
        end
        tracker.accept_cmd(op, id, mode, tv, ok);
    endtask

    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (!steady_block)
        begin
            if (r >= 90)
            begin
                n = $urandom_range(10, 60);
            end
            else if (r >= 50)
            begin
                n = $urandom_range(1, 3);
            end
        end
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (tracker.awaited.size() != 0);
    endtask

    task automatic send_and_gap(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                                input logic [MODE_W-1:0] mode, input logic [TIME_W-1:0] tv,
                                input logic ok);
        issue_cmd(op, id, mode, tv, ok);
        sender_gap();
    endtask

    function automatic logic [TIME_W-1:0] pick_time(input logic [MODE_W-1:0] mode);
        bit [63:0] wide;
        bit [TIME_W-1:0] tv;
        int r;
        wide = {$urandom(), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 6)
        begin
            return wide[TIME_W-1:0];
        end
        if (mode == MODE_POINT)
        begin
            tv = tracker.clock_ms + TIME_W'($urandom_range(0, 18));
            return (tv >= TIME_W'(3)) ? tv - TIME_W'(3) : tv;
        end
        if (r < 16)
        begin
            return TIME_W'($urandom_range(0, 200));
        end
        return TIME_W'($urandom_range(0, 12));
    endfunction

    task automatic random_cmd(output bit counted);
        bit [63:0] wide;
        logic [OP_W-1:0] op;
        logic [ID_W-1:0] id;
        logic [MODE_W-1:0] mode;
        logic [TIME_W-1:0] tv;
        logic ok;
        int r;
        r = $urandom_range(0, 99);
        op = (r < 40) ? OP_SCHED : (r < 58) ? OP_REMOVE : (r < 95) ? OP_TICK : OP_UNDEF;
        id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom())
                                         : 16'h0100 + ID_W'($urandom_range(0, 23));
        r = $urandom_range(0, 9);
        mode = (r < 4) ? MODE_SINGLE : (r < 7) ? MODE_REPEAT : (r < 9) ? MODE_POINT : MODE_UNDEF;
        ok = ($urandom_range(0, 9) != 0);
        if (op == OP_SCHED)
        begin
            tv = pick_time(mode);
        end
        else
        begin
            wide = {$urandom(), $urandom()};
            tv = wide[TIME_W-1:0];
        end
        counted = (op != OP_UNDEF);
        send_and_gap(op, id, mode, tv, ok);
    endtask

    initial
    begin
        int sent;
        bit counted;
        rst_n <= 1'b0;
        start <= 1'b0;
        opcode <= OP_SCHED;
        task_id <= '0;
        sched_mode <= MODE_SINGLE;
        time_value <= '0;
        task_ok <= 1'b0;
        steady_block = 1'b1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, rejects, overwrite, saturation, zero period, full table
        send_and_gap(OP_SCHED, 16'h0000, MODE_SINGLE, '0, 1'b1);
        send_and_gap(OP_SCHED, 16'hFFFF, MODE_REPEAT, 48'd2, 1'b1);
        send_and_gap(OP_SCHED, 16'h0005, MODE_POINT, '0, 1'b1);
        send_and_gap(OP_SCHED, 16'h0006, MODE_SINGLE, 48'd4, 1'b0);
        send_and_gap(OP_SCHED, 16'h0007, MODE_UNDEF, 48'd4, 1'b1);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        send_and_gap(OP_SCHED, 16'h0008, MODE_POINT, 48'd1, 1'b1);
        send_and_gap(OP_SCHED, 16'hFFFF, MODE_SINGLE, 48'd3, 1'b1);
        send_and_gap(OP_REMOVE, 16'h1234, MODE_SINGLE, '0, 1'b1);
        send_and_gap(OP_REMOVE, 16'hFFFF, MODE_SINGLE, '0, 1'b1);
        send_and_gap(OP_SCHED, 16'h0009, MODE_SINGLE, {TIME_W{1'b1}}, 1'b1);
        send_and_gap(OP_SCHED, 16'h000A, MODE_REPEAT, '0, 1'b1);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        send_and_gap(OP_REMOVE, 16'h000A, MODE_SINGLE, '0, 1'b1);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        send_and_gap(OP_UNDEF, 16'hFFFF, MODE_UNDEF, {TIME_W{1'b1}}, 1'b1);
        send_and_gap(OP_REMOVE, 16'h0009, MODE_SINGLE, '0, 1'b1);
        for (int i = 0; i < SLOTS; i++)
        begin
            send_and_gap(OP_SCHED, 16'h0100 + ID_W'(i), MODE_SINGLE, 48'd1, 1'b1);
        end
        send_and_gap(OP_SCHED, 16'h0200, MODE_SINGLE, 48'd1, 1'b1);
        send_and_gap(OP_SCHED, 16'h0105, MODE_REPEAT, 48'd1, 1'b1);
        send_and_gap(OP_TICK, 16'h0000, MODE_SINGLE, '0, 1'b0);
        drain_results();

        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            if (sent % 20 == 0)
            begin
                steady_block = ($urandom_range(0, 9) < 3);
            end
            random_cmd(counted);
            if (counted)
            begin
                sent++;
                if (sent % 50 == 0)
                begin
                    drain_results();
                end
            end
        end

        drain_results();
        repeat (2 * SLOTS + 8) @(posedge clk);
        $display("commands: %0d, result words checked: %0d, fired: %0d, widest burst: %0d",
                 tracker.cmds, tracker.words, tracker.fires, tracker.widest_burst);
        $display("errors: %0d, final clock %0d ms", tracker.errors, tracker.clock_ms);
        if (tracker.errors == 0 && tracker.awaited.size() == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/dts_pkg.sv
rtl/dts_ctrl.sv
rtl/dts_dp.sv
rtl/deadline_task_scheduler.sv
tb/sv/deadline_task_scheduler_tb.sv
